FILE: rtl/fbf_pkg.sv
package fbf_pkg;

    localparam int MAX_ROWS    = 16;
    localparam int MAX_COLS    = 64;
    localparam int MAX_HASHES  = 8;
    localparam int KEY_BYTES   = 8;
    localparam int TABLE_CELLS = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W      = $clog2(TABLE_CELLS);

    localparam logic [ADDR_W-1:0] ADDR_ONE = ADDR_W'(1);

    localparam logic [31:0] SEED_ONE = 32'hAAAAAAAA;
    localparam logic [31:0] SEED_TWO = 32'hBBBBBBBB;
    localparam logic [31:0] C1 = 32'hcc9e2d51;
    localparam logic [31:0] C2 = 32'h1b873593;
    localparam logic [31:0] C3 = 32'he6546b64;
    localparam logic [31:0] F1 = 32'h85ebca6b;
    localparam logic [31:0] F2 = 32'hc2b2ae35;

    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;
    localparam logic [1:0] REG_HASH = 2'd2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_CHECK  = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_HASH, ST_FIN, ST_MOD, ST_CELL, ST_COL, ST_WAIT, ST_CMP,
        ST_OUT
    } t_state;

    // datapath step selects
    typedef enum logic [3:0] {
        OP_NONE, OP_CLEAR, OP_LOAD, OP_BLK_A, OP_BLK_B, OP_FIN_A, OP_FIN_B,
        OP_MOD_ROW, OP_ADDR, OP_MOD_COL, OP_READ, OP_ACCESS, OP_DONE
    } t_op;

    typedef struct packed {
        t_op  op;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic hash_done;
        logic fin_done;
        logic mod_done;
        logic cells_done;
    } t_status;

endpackage

FILE: rtl/fingerprint_bloom_filter.sv
// Fingerprint Bloom filter, 16x64 byte table, MurmurHash3-32 double hashing.
// One request at a time. A request runs two steps per 4-byte key block (at least
// one), six finaliser steps, eight steps of row modulo, and per cell a column
// load, eight modulo steps, a table read and a compare or write. When done the
// block returns to idle and the result register holds the result until it is
// taken; a newer result waits until then. After reset the table is swept to zero,
// and no request is accepted during the sweep.
module fingerprint_bloom_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [63:0] i_key_bytes,
    input  logic [3:0]  i_key_length,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_present,
    output logic [31:0] o_items_added
);

    fbf_pkg::t_cmd    cmd;
    fbf_pkg::t_status status;

    fbf_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_out_stall(i_stall), .o_valid(o_valid), .i_status(status), .o_cmd(cmd)
    );

    fbf_dpath u_dpath (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_command(i_command), .i_key_bytes(i_key_bytes), .i_key_length(i_key_length),
        .o_present(o_present), .o_items_added(o_items_added)
    );

endmodule

FILE: rtl/fbf_ctrl.sv
module fbf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_out_stall,
    output logic              o_valid,
    input  fbf_pkg::t_status  i_status,
    output fbf_pkg::t_cmd     o_cmd
);

    fbf_pkg::t_state r_state, n_state;
    logic            r_sub, n_sub;
    logic            r_valid, n_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fbf_pkg::ST_CLEAR;
            r_sub   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sub   <= n_sub;
            r_valid <= n_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_sub         = r_sub;
        n_valid       = r_valid;
        o_cmd.op      = fbf_pkg::OP_NONE;
        o_cmd.out_load = 1'b0;
        o_stall       = 1'b1;
        if (r_valid && !i_out_stall) n_valid = 1'b0;
        unique case (r_state)
            fbf_pkg::ST_CLEAR: begin
                o_cmd.op = fbf_pkg::OP_CLEAR;
                if (i_status.clear_done) n_state = fbf_pkg::ST_IDLE;
            end
            fbf_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.op = fbf_pkg::OP_LOAD;
                    n_state  = fbf_pkg::ST_HASH;
                    n_sub    = 1'b0;
                end
            end
            fbf_pkg::ST_HASH: begin
                // two steps per block: mix, then merge into both hashes
                o_cmd.op = r_sub ? fbf_pkg::OP_BLK_B : fbf_pkg::OP_BLK_A;
                n_sub    = !r_sub;
                if (r_sub && i_status.hash_done) n_state = fbf_pkg::ST_FIN;
            end
            fbf_pkg::ST_FIN: begin
                o_cmd.op = r_sub ? fbf_pkg::OP_FIN_B : fbf_pkg::OP_FIN_A;
                n_sub    = !r_sub;
                if (r_sub && i_status.fin_done) n_state = fbf_pkg::ST_MOD;
            end
            fbf_pkg::ST_MOD: begin
                o_cmd.op = fbf_pkg::OP_MOD_ROW;
                if (i_status.mod_done) n_state = fbf_pkg::ST_CELL;
            end
            fbf_pkg::ST_CELL: begin
                o_cmd.op = fbf_pkg::OP_ADDR;
                n_state  = fbf_pkg::ST_COL;
            end
            fbf_pkg::ST_COL: begin
                o_cmd.op = fbf_pkg::OP_MOD_COL;
                if (i_status.mod_done) n_state = fbf_pkg::ST_WAIT;
            end
            fbf_pkg::ST_WAIT: begin
                o_cmd.op = fbf_pkg::OP_READ;
                n_state  = fbf_pkg::ST_CMP;
            end
            fbf_pkg::ST_CMP: begin
                o_cmd.op = fbf_pkg::OP_ACCESS;
                n_state  = i_status.cells_done ? fbf_pkg::ST_OUT : fbf_pkg::ST_CELL;
            end
            fbf_pkg::ST_OUT: begin
                if (!n_valid) begin
                    o_cmd.op       = fbf_pkg::OP_DONE;
                    o_cmd.out_load = 1'b1;
                    n_valid        = 1'b1;
                    n_state        = fbf_pkg::ST_IDLE;
                end
            end
            default: n_state = fbf_pkg::ST_IDLE;
        endcase
    end

    assign o_valid = r_valid;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != fbf_pkg::ST_IDLE) |-> o_stall)
        else $error("request taken while busy");
    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_valid)
        else $error("result not raised");
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fbf_pkg::ST_CLEAR) |-> !r_valid)
        else $error("result during clear");

endmodule

FILE: rtl/fbf_dpath.sv
module fbf_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fbf_pkg::t_cmd     i_cmd,
    output fbf_pkg::t_status  o_status,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [6:0]        i_cfg_data,
    input  logic              i_command,
    input  logic [63:0]       i_key_bytes,
    input  logic [3:0]        i_key_length,
    output logic              o_present,
    output logic [31:0]       o_items_added
);

    logic [4:0]  r_rows;
    logic [6:0]  r_cols;
    logic [3:0]  r_nh;
    logic [31:0] r_count;
    logic [7:0]  mem [fbf_pkg::TABLE_CELLS];
    logic [7:0]  r_rd;
    logic [fbf_pkg::ADDR_W-1:0] r_clr, r_addr, r_rowbase;

    logic        r_cmd;
    logic [63:0] r_key;
    logic [3:0]  r_len;
    logic [1:0]  r_blk;      // blocks left including tail
    logic [31:0] r_h1, r_h2, r_k;
    logic [1:0]  r_fstep;
    logic [4:0]  r_rows_u;
    logic [6:0]  r_cols_u;
    logic [3:0]  r_nh_u;
    logic [31:0] r_dvd, r_csum;
    logic [6:0]  r_rem;
    logic [2:0]  r_dstep;
    logic [3:0]  r_row;
    logic [3:0]  r_i;
    logic [7:0]  r_fp;
    logic        r_pres;
    logic        r_present;
    logic [31:0] r_items;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= 5'd16;
            r_cols  <= 7'd64;
            r_nh    <= 4'd3;
            r_count <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    fbf_pkg::REG_ROWS: r_rows <= i_cfg_data[4:0];
                    fbf_pkg::REG_COLS: r_cols <= i_cfg_data;
                    fbf_pkg::REG_HASH: r_nh   <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_cmd.op == fbf_pkg::OP_ACCESS && r_cmd == fbf_pkg::CMD_INSERT
                && o_status.cells_done)
                r_count <= r_count + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr <= '0;
        else if (i_cmd.op == fbf_pkg::OP_CLEAR) r_clr <= r_clr + fbf_pkg::ADDR_ONE;
    end

    logic [3:0] len_sat;
    assign len_sat = (i_key_length > 4'(fbf_pkg::KEY_BYTES)) ? 4'(fbf_pkg::KEY_BYTES)
                                                              : i_key_length;

    // current tail or full block of the key
    logic [31:0] blk_word, blk_mask, tail_rem;
    logic [1:0]  blk_idx;
    logic        full_blk;
    always_comb begin
        blk_idx  = r_len[3:2] - r_blk + ((r_len[1:0] != 2'd0) ? 2'd1 : 2'd0);
        blk_word = blk_idx[0] ? r_key[63:32] : r_key[31:0];
        full_blk = (blk_idx < r_len[3:2]);
        unique case (r_len[1:0])
            2'd1: blk_mask = 32'h000000ff;
            2'd2: blk_mask = 32'h0000ffff;
            2'd3: blk_mask = 32'h00ffffff;
            default: blk_mask = 32'hffffffff;
        endcase
        tail_rem = full_blk ? blk_word : (blk_word & blk_mask);
    end

    // first half of the block mix; the second multiply runs in the merge step
    logic [31:0] mk, rk;
    assign mk = tail_rem * fbf_pkg::C1;
    assign rk = {mk[16:0], mk[31:17]};

    logic [31:0] kfin, t1, t2;
    assign kfin = r_k * fbf_pkg::C2;
    always_comb begin
        t1 = r_h1 ^ kfin;
        t2 = r_h2 ^ kfin;
        if (full_blk) begin
            t1 = {t1[18:0], t1[31:19]};
            t2 = {t2[18:0], t2[31:19]};
            t1 = (t1 << 2) + t1 + fbf_pkg::C3;
            t2 = (t2 << 2) + t2 + fbf_pkg::C3;
        end
    end

    logic [31:0] fm1, fm2, fx1, fx2;
    assign fm1 = r_h1 * ((r_fstep == 2'd1) ? fbf_pkg::F1 : fbf_pkg::F2);
    assign fm2 = r_h2 * ((r_fstep == 2'd1) ? fbf_pkg::F1 : fbf_pkg::F2);
    assign fx1 = r_h1 ^ (r_h1 >> 16);
    assign fx2 = r_h2 ^ (r_h2 >> 16);

    // remainder, four dividend bits a step, MSB first
    logic [6:0] div_d;
    logic [7:0] rem_t;
    logic [6:0] rem_next;
    always_comb begin
        div_d = (i_cmd.op == fbf_pkg::OP_MOD_COL) ? r_cols_u : {2'd0, r_rows_u};
        rem_t = {1'b0, r_rem};
        for (int j = 3; j >= 0; j--) begin
            rem_t = {rem_t[6:0], r_dvd[28 + j]};
            if (rem_t >= {1'b0, div_d}) rem_t = rem_t - {1'b0, div_d};
        end
        rem_next = rem_t[6:0];
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            fbf_pkg::OP_LOAD: begin
                r_cmd <= i_command;
                r_key <= i_key_bytes;
                r_len <= len_sat;
                r_blk <= len_sat[3:2] + ((len_sat[1:0] != 2'd0) ? 2'd1 : 2'd0);
                r_h1  <= fbf_pkg::SEED_ONE;
                r_h2  <= fbf_pkg::SEED_TWO;
                r_rows_u <= (r_rows == 5'd0) ? 5'd1
                          : ((r_rows > 5'(fbf_pkg::MAX_ROWS)) ? 5'(fbf_pkg::MAX_ROWS) : r_rows);
                r_cols_u <= (r_cols == 7'd0) ? 7'd1
                          : ((r_cols > 7'(fbf_pkg::MAX_COLS)) ? 7'(fbf_pkg::MAX_COLS) : r_cols);
                r_nh_u   <= (r_nh == 4'd0) ? 4'd1
                          : ((r_nh > 4'(fbf_pkg::MAX_HASHES)) ? 4'(fbf_pkg::MAX_HASHES) : r_nh);
                r_fstep  <= 2'd0;
                r_i      <= 4'd0;
                r_pres   <= 1'b1;
            end
            fbf_pkg::OP_BLK_A: if (r_blk != 2'd0) r_k <= rk;
            fbf_pkg::OP_BLK_B: begin
                if (r_blk != 2'd0) begin
                    r_h1  <= t1;
                    r_h2  <= t2;
                    r_blk <= r_blk - 2'd1;
                end
            end
            fbf_pkg::OP_FIN_A: begin
                unique case (r_fstep)
                    2'd0: begin
                        r_h1 <= (r_h1 ^ {28'd0, r_len}) ^ ((r_h1 ^ {28'd0, r_len}) >> 16);
                        r_h2 <= (r_h2 ^ {28'd0, r_len}) ^ ((r_h2 ^ {28'd0, r_len}) >> 16);
                    end
                    2'd1: begin r_h1 <= fm1; r_h2 <= fm2; end
                    2'd2: begin r_h1 <= fm1; r_h2 <= fm2; end
                    default: ;
                endcase
            end
            fbf_pkg::OP_FIN_B: begin
                unique case (r_fstep)
                    2'd1: begin r_h1 <= r_h1 ^ (r_h1 >> 13); r_h2 <= r_h2 ^ (r_h2 >> 13); end
                    2'd2: begin
                        r_h1    <= fx1;
                        r_h2    <= fx2;
                        r_dvd   <= fx1;
                        r_csum  <= fx1;
                        r_rem   <= '0;
                        r_dstep <= '0;
                        r_fp    <= (fx2[7:0] == 8'd0) ? 8'd1 : fx2[7:0];
                    end
                    default: ;
                endcase
                r_fstep <= r_fstep + 2'd1;
            end
            fbf_pkg::OP_MOD_ROW: begin
                r_dvd   <= {r_dvd[27:0], 4'd0};
                r_rem   <= rem_next;
                r_dstep <= r_dstep + 3'd1;
                if (r_dstep == 3'd7) r_row <= rem_next[3:0];
            end
            fbf_pkg::OP_ADDR: begin
                r_dvd     <= r_csum;
                r_rem     <= '0;
                r_dstep   <= '0;
                r_rowbase <= {6'd0, r_row} * {3'd0, r_cols_u};
            end
            fbf_pkg::OP_MOD_COL: begin
                r_dvd   <= {r_dvd[27:0], 4'd0};
                r_rem   <= rem_next;
                r_dstep <= r_dstep + 3'd1;
                if (r_dstep == 3'd7) r_addr <= r_rowbase + {3'd0, rem_next};
            end
            fbf_pkg::OP_READ: r_rd <= mem[r_addr];
            fbf_pkg::OP_ACCESS: begin
                if (r_cmd == fbf_pkg::CMD_CHECK && r_rd != r_fp) r_pres <= 1'b0;
                r_i    <= r_i + 4'd1;
                r_csum <= r_csum + r_h2;
            end
            fbf_pkg::OP_DONE: begin
                r_present <= (r_cmd == fbf_pkg::CMD_CHECK) && r_pres;
                r_items   <= r_count;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == fbf_pkg::OP_CLEAR) mem[r_clr] <= 8'd0;
        else if (i_cmd.op == fbf_pkg::OP_ACCESS && r_cmd == fbf_pkg::CMD_INSERT)
            mem[r_addr] <= r_fp;
    end

    assign o_status.clear_done = (r_clr == '1);
    assign o_status.hash_done  = (r_blk <= 2'd1);
    assign o_status.fin_done   = (r_fstep == 2'd2);
    assign o_status.mod_done   = (r_dstep == 3'd7);
    assign o_status.cells_done = (r_i + 4'd1 >= r_nh_u);
    assign o_present     = r_present;
    assign o_items_added = r_items;

    a_fp_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == fbf_pkg::OP_ACCESS) |-> (r_fp != 8'd0))
        else $error("zero fingerprint");
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == fbf_pkg::OP_READ) |-> ({1'b0, r_row} < r_rows_u))
        else $error("row out of range");
    a_insert_no_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == fbf_pkg::OP_DONE && r_cmd == fbf_pkg::CMD_INSERT) |=> !r_present)
        else $error("insert reported present");

endmodule
